// ===== rtl/core/npps_pkg.sv =====
`default_nettype none
package npps_pkg;
  localparam int MaxSideDef = 8;
  localparam int OutRows = 8;

  typedef enum logic [2:0] {
    KindFree   = 3'd0,
    KindQueen  = 3'd1,
    KindKnight = 3'd2,
    KindBishop = 3'd3,
    KindRook   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StStep,
    StCheck,
    StPop,
    StEmit
  } state_e;

  localparam logic [0:0] RegSize = 1'b0;
  localparam logic [0:0] RegKind = 1'b1;

  typedef struct packed {
    logic       go;
    logic [2:0] row;
    logic [2:0] col;
    logic [3:0] n;
    logic [2:0] kind;
  } chk_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/npps_check.sv =====
`default_nettype none
// Serial attack check: one probe per cycle against the board, up to 8
// dependent steps per ray but each step is a single register probe.
module npps_check
  import npps_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire chk_req_t      req_i,
  input  wire logic [63:0]   board_i,
  output logic               done_o,
  output logic               safe_o
);
  // probe index: 0..7 left, 8..15 up, 16..23 upleft, 24..31 upright, 32..39 knight
  logic [5:0] idx_q, idx_d;
  logic       run_q, run_d;
  logic       hit_q, hit_d;
  chk_req_t   r_q;
  logic signed [4:0] pr, pc;
  logic       applies, inb;
  logic [2:0] st;

  always_comb begin
    st = idx_q[2:0];
    pr = 5'sd0;
    pc = 5'sd0;
    applies = 1'b0;
    unique case (idx_q[5:3])
      3'd0: begin
        pr = $signed({2'b0, r_q.row});
        pc = $signed({2'b0, st});
        applies = (r_q.kind == KindQueen || r_q.kind == KindRook) && st < r_q.col;
      end
      3'd1: begin
        pr = $signed({2'b0, st});
        pc = $signed({2'b0, r_q.col});
        applies = (r_q.kind == KindQueen || r_q.kind == KindRook) && st < r_q.row;
      end
      3'd2: begin
        pr = $signed({2'b0, r_q.row}) - $signed({2'b0, st}) - 5'sd1;
        pc = $signed({2'b0, r_q.col}) - $signed({2'b0, st}) - 5'sd1;
        applies = r_q.kind == KindQueen || r_q.kind == KindBishop;
      end
      3'd3: begin
        pr = $signed({2'b0, r_q.row}) - $signed({2'b0, st}) - 5'sd1;
        pc = $signed({2'b0, r_q.col}) + $signed({2'b0, st}) + 5'sd1;
        applies = r_q.kind == KindQueen || r_q.kind == KindBishop;
      end
      3'd4: begin
        pr = $signed({2'b0, r_q.row}) + ((st[2] ? 5'sd1 : -5'sd2) + (st[1] ? 5'sd1 : 5'sd0)
             - (st[2] ? 5'sd0 : 5'sd0));
        // rows: -2,-2,-1,-1,1,1,2,2 ; cols: -1,1,-2,2,-2,2,-1,1
        unique case (st[2:1])
          2'd0: pr = $signed({2'b0, r_q.row}) - 5'sd2;
          2'd1: pr = $signed({2'b0, r_q.row}) - 5'sd1;
          2'd2: pr = $signed({2'b0, r_q.row}) + 5'sd1;
          default: pr = $signed({2'b0, r_q.row}) + 5'sd2;
        endcase
        if (st[2:1] == 2'd0 || st[2:1] == 2'd3)
          pc = $signed({2'b0, r_q.col}) + (st[0] ? 5'sd1 : -5'sd1);
        else
          pc = $signed({2'b0, r_q.col}) + (st[0] ? 5'sd2 : -5'sd2);
        applies = r_q.kind == KindKnight;
      end
      default: ;
    endcase
    inb = pr >= 0 && pc >= 0 && pr < $signed({1'b0, r_q.n}) && pc < $signed({1'b0, r_q.n});
  end

  always_comb begin
    run_d = run_q;
    idx_d = idx_q;
    hit_d = hit_q;
    done_o = 1'b0;
    if (req_i.go) begin
      run_d = 1'b1;
      idx_d = '0;
      hit_d = 1'b0;
    end else if (run_q) begin
      if (applies && inb && board_i[{pr[2:0], pc[2:0]}]) hit_d = 1'b1;
      if (idx_q == 6'd39) begin
        run_d = 1'b0;
        done_o = 1'b1;
      end else begin
        idx_d = idx_q + 6'd1;
      end
    end
  end
  assign safe_o = !(hit_q || (applies && inb && board_i[{pr[2:0], pc[2:0]}]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      idx_q <= '0;
      hit_q <= 1'b0;
    end else begin
      run_q <= run_d;
      idx_q <= idx_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) r_q <= req_i;
  end

  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> run_q) else $error("check done while idle");
  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.go |=> run_q && idx_q == 6'd0) else $error("check did not start");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !run_q) else $error("check kept running");
endmodule
`default_nettype wire

// ===== rtl/core/n_piece_placement_search.sv =====
`default_nettype none
// Channel   | Signals                                     | Direction
// command   | start_i, start_req_i, busy_o                | in/out
// result    | result_valid_o, row_index_o, row_cells_o,   | out
//           | found_o, last_row_o                         |
// config    | psel_i..pwdata_i, prdata_o, pready_o        | in/out
// A start with start_req_i=0 is ignored and gives nothing.
// A search tries cells one per visit; each candidate runs the shared
// attack checker, so total time is data dependent.
// Results stream one per cycle after the search; the receiver cannot stall.
// Reset clears control and sets board_size 8, piece_kind queen.
module n_piece_placement_search
  import npps_pkg::*;
#(
  parameter int MAX_SIDE = MaxSideDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        start_req_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output logic [2:0]       row_index_o,
  output logic [7:0]       row_cells_o,
  output logic             found_o,
  output logic             last_row_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  localparam int SideCap = (MAX_SIDE < OutRows) ? MAX_SIDE : OutRows;

  state_e st_q, st_d;
  logic [3:0] size_q;
  logic [2:0] kind_q;
  logic [3:0] n_q, n_d;
  logic [3:0] row_q, row_d, col_q, col_d, cnt_q, cnt_d;
  logic [63:0] board_q, board_d;
  logic [5:0] stack_q [8];
  logic       push, fnd_q, fnd_d;
  logic [2:0] emit_q, emit_d;
  chk_req_t   creq;
  logic       cdone, csafe;
  logic [3:0] nsat;
  logic [5:0] top;

  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? {29'd0, kind_q} : {28'd0, size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd8;
      kind_q <= KindQueen;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[1:0] == 2'd0) begin
      if (paddr_i[2] == RegSize) size_q <= pwdata_i[3:0];
      else if (paddr_i[2] == RegKind) kind_q <= pwdata_i[2:0];
    end
  end

  always_comb begin
    nsat = size_q;
    if (nsat == 4'd0) nsat = 4'd1;
    if (nsat > 4'(SideCap)) nsat = 4'(SideCap);
  end

  npps_check u_check (
    .clk_i, .rst_ni, .req_i(creq), .board_i(board_q), .done_o(cdone), .safe_o(csafe)
  );

  assign top = stack_q[3'(cnt_q - 4'd1)];

  always_comb begin
    st_d = st_q; n_d = n_q; row_d = row_q; col_d = col_q; cnt_d = cnt_q;
    board_d = board_q; fnd_d = fnd_q; emit_d = emit_q; push = 1'b0;
    creq = '{go: 1'b0, row: row_q[2:0], col: col_q[2:0], n: n_q, kind: kind_q};
    result_valid_o = 1'b0;
    busy_o = st_q != StIdle;
    unique case (st_q)
      StIdle: if (start_i && start_req_i) begin
        n_d = nsat; row_d = '0; col_d = '0; cnt_d = '0; board_d = '0;
        st_d = StStep;
      end
      StStep: begin
        if (cnt_q == n_q) begin
          fnd_d = 1'b1; emit_d = '0; st_d = StEmit;
        end else if (col_q >= n_q) begin
          row_d = row_q + 4'd1; col_d = '0;
        end else if (row_q >= n_q) begin
          if (cnt_q == 4'd0) begin
            fnd_d = 1'b0; emit_d = '0; st_d = StEmit;
          end else st_d = StPop;
        end else begin
          creq.go = 1'b1; st_d = StCheck;
        end
      end
      StCheck: if (cdone) begin
        if (csafe) begin
          board_d[{row_q[2:0], col_q[2:0]}] = 1'b1;
          push = 1'b1;
          cnt_d = cnt_q + 4'd1;
        end
        col_d = col_q + 4'd1;
        st_d = StStep;
      end
      StPop: begin
        cnt_d = cnt_q - 4'd1;
        board_d[top] = 1'b0;
        row_d = {1'b0, top[5:3]};
        col_d = {1'b0, top[2:0]} + 4'd1;
        st_d = StStep;
      end
      StEmit: begin
        result_valid_o = 1'b1;
        if (!fnd_q || emit_q == 3'(n_q - 4'd1)) st_d = StIdle;
        else emit_d = emit_q + 3'd1;
      end
      default: st_d = StIdle;
    endcase
  end

  assign row_index_o = fnd_q ? emit_q : 3'd0;
  assign row_cells_o = fnd_q ? board_q[{emit_q, 3'd0} +: 8] : 8'd0;
  assign found_o = fnd_q;
  assign last_row_o = !fnd_q || emit_q == 3'(n_q - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; n_q <= 4'd1; row_q <= '0; col_q <= '0; cnt_q <= '0;
      board_q <= '0; fnd_q <= 1'b0; emit_q <= '0;
    end else begin
      st_q <= st_d; n_q <= n_d; row_q <= row_d; col_q <= col_d; cnt_q <= cnt_d;
      board_q <= board_d; fnd_q <= fnd_d; emit_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) stack_q[cnt_q[2:0]] <= {row_q[2:0], col_q[2:0]};
  end

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= n_q) else $error("placed count above size");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_row_o |=> !busy_o) else $error("busy after last");
endmodule
`default_nettype wire
